### rtl/gate_delay_burst_generator_macros.svh
// Assertion helpers for the gate delay / burst generator.
// Both macros sample on the rising edge of clock and are off during reset.
`ifndef GATE_DELAY_BURST_GENERATOR_MACROS_SVH
`define GATE_DELAY_BURST_GENERATOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define GDBG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GDBG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gdbg_pkg.sv
package gdbg_pkg;

   localparam int PULSE_BITS    = 6;
   localparam int BURST_OFFSET  = 10;
   localparam int TIMES_SHIFT   = 5;
   localparam int TIMES_LIMIT   = 33;
   localparam int TIMES_CLAMP   = 32;
   localparam int WIDTH_SHIFT   = 2;
   localparam int RSP_DATA_BITS = 8;

   // Request field positions in tdata; the knob fields follow from bit 5.
   localparam int TICK_BIT      = 0;
   localparam int MODE_BIT      = 1;
   localparam int ENABLE_BIT    = 2;
   localparam int GATE_BIT      = 3;
   localparam int BUTTON_BIT    = 4;
   localparam int KNOB_LSB      = 5;

   typedef struct packed {
      logic                  trigger_latch;
      logic                  gate_level;
      logic                  prev_gate;
      logic                  prev_button;
      logic [PULSE_BITS-1:0] pulse_count;
   } gdbg_flags_type;

   localparam gdbg_flags_type FLAGS_RESET = '{
      trigger_latch: 1'b0,
      gate_level:    1'b0,
      prev_gate:     1'b0,
      prev_button:   1'b0,
      pulse_count:   PULSE_BITS'(1)
   };

endpackage

### rtl/gdbg_eval.sv
module gdbg_eval #(
   parameter int COUNTER_BITS = 16,
   parameter int SAMPLE_BITS  = 10
) (
   input  logic                    tick,
   input  logic                    mode,
   input  logic                    enable,
   input  logic                    gate_level,
   input  logic                    button_level,
   input  logic [SAMPLE_BITS-1:0]  knob_one,
   input  logic [SAMPLE_BITS-1:0]  control_voltage,
   input  logic [SAMPLE_BITS-1:0]  knob_two,
   input  logic [COUNTER_BITS-1:0] counter_cur,
   input  gdbg_pkg::gdbg_flags_type flags_cur,
   output logic [COUNTER_BITS-1:0] counter_nxt,
   output gdbg_pkg::gdbg_flags_type flags_nxt,
   output logic                    level_out
);
   import gdbg_pkg::*;

   localparam int WideBits = (COUNTER_BITS > SAMPLE_BITS + 3) ? COUNTER_BITS
                                                              : SAMPLE_BITS + 3;
   localparam logic [COUNTER_BITS-1:0] CntMax = {COUNTER_BITS{1'b1}};

   logic [SAMPLE_BITS:0]   delay_sum;
   logic [SAMPLE_BITS-1:0] delay;
   logic [WideBits-1:0]    delay_w;
   logic [WideBits-1:0]    delay_end;
   logic [WideBits-1:0]    period;
   logic [WideBits-1:0]    half_period;
   logic [SAMPLE_BITS:0]   count_sum;
   logic [WideBits-1:0]    times_raw;
   logic [WideBits-1:0]    times;
   logic                   trig;
   logic [COUNTER_BITS-1:0] cnt_work;
   logic [WideBits-1:0]    cnt_w;

   assign delay_sum   = {1'b0, knob_one} + {1'b0, control_voltage};
   assign delay       = delay_sum[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}}
                                               : delay_sum[SAMPLE_BITS-1:0];
   assign delay_w     = WideBits'(delay);
   assign delay_end   = delay_w + (WideBits'(knob_two) << WIDTH_SHIFT) + WideBits'(1);
   assign period      = WideBits'(knob_one >> 1) + WideBits'(BURST_OFFSET);
   assign half_period = period >> 1;
   assign count_sum   = {1'b0, control_voltage} + {1'b0, knob_two};
   assign times_raw   = WideBits'(count_sum >> TIMES_SHIFT) + WideBits'(1);
   // A count past the limit folds back to the clamp value.
   assign times       = (times_raw > WideBits'(TIMES_LIMIT)) ? WideBits'(TIMES_CLAMP)
                                                             : times_raw;
   assign trig        = (gate_level && !flags_cur.prev_gate) ||
                        (!button_level && flags_cur.prev_button);

   always_comb begin
      cnt_work = counter_cur;
      if (tick && counter_cur != CntMax) begin
         cnt_work = counter_cur + COUNTER_BITS'(1);
      end
      flags_nxt = flags_cur;
      if (enable) begin
         flags_nxt.prev_gate   = gate_level;
         flags_nxt.prev_button = button_level;
         if (trig) begin
            flags_nxt.trigger_latch = 1'b1;
            if (mode) begin
               cnt_work = '0;
            end else begin
               flags_nxt.pulse_count = '0;
            end
         end
      end
      cnt_w = WideBits'(cnt_work);
      if (enable) begin
         if (mode) begin
            flags_nxt.gate_level = flags_nxt.trigger_latch && (cnt_w >= delay_w);
            if (flags_nxt.trigger_latch && cnt_w >= delay_end) begin
               flags_nxt.trigger_latch = 1'b0;
            end
         end else if (flags_nxt.trigger_latch &&
                      WideBits'(flags_nxt.pulse_count) <= times) begin
            if (cnt_w <= half_period) begin
               flags_nxt.gate_level = 1'b1;
            end else if (cnt_w < period) begin
               flags_nxt.gate_level = 1'b0;
            end else begin
               // End of one pulse period: restart the counter, level holds.
               cnt_work              = '0;
               flags_nxt.pulse_count = flags_nxt.pulse_count + PULSE_BITS'(1);
            end
         end
      end
      counter_nxt = cnt_work;
      level_out   = enable && flags_nxt.gate_level;
   end

endmodule

### rtl/gate_delay_burst_generator.sv
// Channel | Ports     | Payload
// request | req_*     | tdata: tick, mode, enable, gate_level, button_level,
//         |           |        knob_one, control_voltage, knob_two
// response| rsp_*     | tdata: level_out
//
// One response per request. A request is registered, evaluated against the
// counter and flag registers, and written to the response register; a new
// request can enter every cycle while the response side is not stalled.
// Reset is synchronous and clears the counter, the flags and both valid bits.
// A stalled response holds the pipeline; the input register still takes a
// request while the response register is waiting, then tready drops.
module gate_delay_burst_generator #(
   parameter int COUNTER_BITS = 16,
   parameter int SAMPLE_BITS  = 10,
   localparam int ReqDataBits = ((5 + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tick, mode, enable, gate_level, button_level, knob_one,
   // control_voltage, knob_two, zero fill
   input  logic [ReqDataBits-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // level_out, zero fill
   output logic [7:0]             rsp_tdata
);
   import gdbg_pkg::*;

   localparam int CvLsb = KNOB_LSB + SAMPLE_BITS;
   localparam int K2Lsb = KNOB_LSB + 2 * SAMPLE_BITS;

   logic                    stage_valid_ff;
   logic [ReqDataBits-1:0]  stage_data_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_gate_ff;
   logic [COUNTER_BITS-1:0] cnt_ff;
   logic [COUNTER_BITS-1:0] cnt_in;
   gdbg_flags_type          flags_ff;
   gdbg_flags_type          flags_in;
   logic                    gate_in;
   logic                    advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - 1)'(0), rsp_gate_ff};

   gdbg_eval #(
      .COUNTER_BITS(COUNTER_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_eval (
      .tick           (stage_data_ff[TICK_BIT]),
      .mode           (stage_data_ff[MODE_BIT]),
      .enable         (stage_data_ff[ENABLE_BIT]),
      .gate_level     (stage_data_ff[GATE_BIT]),
      .button_level   (stage_data_ff[BUTTON_BIT]),
      .knob_one       (stage_data_ff[KNOB_LSB +: SAMPLE_BITS]),
      .control_voltage(stage_data_ff[CvLsb +: SAMPLE_BITS]),
      .knob_two       (stage_data_ff[K2Lsb +: SAMPLE_BITS]),
      .counter_cur    (cnt_ff),
      .flags_cur      (flags_ff),
      .counter_nxt    (cnt_in),
      .flags_nxt      (flags_in),
      .level_out      (gate_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
         flags_ff       <= FLAGS_RESET;
      end else begin
         if (req_tready) begin
            stage_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= stage_valid_ff;
         end
         if (advance && stage_valid_ff) begin
            cnt_ff   <= cnt_in;
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_data_ff <= req_tdata;
      end
      if (advance && stage_valid_ff) begin
         rsp_gate_ff <= gate_in;
      end
   end

`include "gate_delay_burst_generator_macros.svh"

   `GDBG_ASSERT_SAME(a_ready_low_only_when_full, !req_tready, stage_valid_ff && rsp_valid_ff && !rsp_tready, "request side stalled without a full pipeline")
   `GDBG_ASSERT_NEXT(a_stage_reaches_response, advance && stage_valid_ff, rsp_tvalid, "evaluated request produced no response")
   `GDBG_ASSERT_NEXT(a_disabled_keeps_flags, advance && stage_valid_ff && !stage_data_ff[ENABLE_BIT], flags_ff == $past(flags_ff), "disabled request changed the flag registers")

endmodule

### sim/gate_delay_burst_generator_checker.sv
module gate_delay_burst_generator_checker #(
   parameter int COUNTER_BITS = 16,
   parameter int SAMPLE_BITS  = 10,
   localparam int ReqDataBits = ((5 + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [7:0]             rsp_tdata,
   output int                     failures,
   output int                     pending
);
   import gdbg_pkg::*;

   localparam int SampleMax = (1 << SAMPLE_BITS) - 1;

   // Own copy of the generator state.
   logic [COUNTER_BITS-1:0] ms_ticks;
   logic                    armed;
   logic                    level;
   logic                    last_gate;
   logic                    last_button;
   logic [PULSE_BITS-1:0]   pulses;

   logic gate_due[$];
   logic gate_exp;
   int   mismatch_count;

   // Applies one request to the state and returns the expected output level.
   function automatic logic next_gate_level(input logic [ReqDataBits-1:0] d);
      logic        tick;
      logic        dly;
      logic        en;
      logic        g;
      logic        b;
      logic        trig;
      int unsigned k1;
      int unsigned cv;
      int unsigned k2;
      int unsigned delay;
      int unsigned width;
      int unsigned period;
      int unsigned burst_len;
      tick = d[TICK_BIT];
      dly  = d[MODE_BIT];
      en   = d[ENABLE_BIT];
      g    = d[GATE_BIT];
      b    = d[BUTTON_BIT];
      k1   = 32'(d[KNOB_LSB +: SAMPLE_BITS]);
      cv   = 32'(d[KNOB_LSB + SAMPLE_BITS +: SAMPLE_BITS]);
      k2   = 32'(d[KNOB_LSB + 2 * SAMPLE_BITS +: SAMPLE_BITS]);

      if (tick && ms_ticks != {COUNTER_BITS{1'b1}}) begin
         ms_ticks = ms_ticks + COUNTER_BITS'(1);
      end
      if (!en) begin
         return 1'b0;
      end

      trig        = (g && !last_gate) || (!b && last_button);
      last_gate   = g;
      last_button = b;

      if (dly) begin
         delay = k1 + cv;
         if (delay > SampleMax) begin
            delay = SampleMax;
         end
         width = (k2 << WIDTH_SHIFT) + 1;
         if (trig) begin
            armed    = 1'b1;
            ms_ticks = '0;
         end
         level = armed && (ms_ticks >= delay);
         if (armed && ms_ticks >= delay + width) begin
            armed = 1'b0;
         end
      end else begin
         period    = k1 / 2 + BURST_OFFSET;
         burst_len = ((cv + k2) >> TIMES_SHIFT) + 1;
         if (burst_len > TIMES_LIMIT) begin
            burst_len = TIMES_CLAMP;
         end
         if (trig) begin
            armed  = 1'b1;
            pulses = '0;
         end
         if (armed && pulses <= burst_len) begin
            if (ms_ticks <= period / 2) begin
               level = 1'b1;
            end else if (ms_ticks < period) begin
               level = 1'b0;
            end else begin
               // End of one pulse period: the level holds for this pass.
               ms_ticks = '0;
               pulses   = pulses + PULSE_BITS'(1);
            end
         end
      end
      return level;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ms_ticks       = '0;
         armed          = 1'b0;
         level          = 1'b0;
         last_gate      = 1'b0;
         last_button    = 1'b0;
         pulses         = PULSE_BITS'(1);
         mismatch_count = 0;
         gate_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (gate_due.size() == 0) begin
               $error("level_out: expected nothing, got %0b", rsp_tdata[0]);
               mismatch_count++;
            end else begin
               gate_exp = gate_due.pop_front();
               if (rsp_tdata[0] !== gate_exp) begin
                  $error("level_out: expected %0b, got %0b", gate_exp, rsp_tdata[0]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            gate_due.push_back(next_gate_level(req_tdata));
         end
      end
      failures <= mismatch_count;
      pending  <= gate_due.size();
   end

endmodule

### sim/gate_delay_burst_generator_tb.sv
module gate_delay_burst_generator_tb;
   import gdbg_pkg::*;

   localparam int COUNTER_BITS = 16;
   localparam int SAMPLE_BITS  = 10;
   localparam int REQ_BITS     = ((5 + 3 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_LIMIT   = 1000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;

   int failures;
   int pending;
   int sent_count = 0;
   int idle_cycles = 0;
   int rx_cycle = 0;
   int rx_hold = 0;
   bit calm = 1'b0;
   bit gate_now = 1'b0;
   bit button_now = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   gate_delay_burst_generator #(
      .COUNTER_BITS(COUNTER_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   gate_delay_burst_generator_checker #(
      .COUNTER_BITS(COUNTER_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .failures  (failures),
      .pending   (pending)
   );

   // Offers one request, with random idle cycles ahead of it, and returns
   // at the edge where it is taken.
   task automatic put(input bit tick, input bit mode, input bit en, input bit g, input bit b,
                      input logic [SAMPLE_BITS-1:0] k1, input logic [SAMPLE_BITS-1:0] cv,
                      input logic [SAMPLE_BITS-1:0] k2);
      logic [REQ_BITS-1:0] d;
      d = '0;
      d[TICK_BIT]   = tick;
      d[MODE_BIT]   = mode;
      d[ENABLE_BIT] = en;
      d[GATE_BIT]   = g;
      d[BUTTON_BIT] = b;
      d[KNOB_LSB +: SAMPLE_BITS]                   = k1;
      d[KNOB_LSB + SAMPLE_BITS +: SAMPLE_BITS]     = cv;
      d[KNOB_LSB + 2 * SAMPLE_BITS +: SAMPLE_BITS] = k2;
      gate_now   = g;
      button_now = b;
      while (!calm && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // One trigger followed by ticks; outside wild scenes, enough to play out the delay or the burst.
   task automatic run_scene(input bit dly, input bit wild);
      logic [SAMPLE_BITS-1:0] k1;
      logic [SAMPLE_BITS-1:0] cv;
      logic [SAMPLE_BITS-1:0] k2;
      int unsigned span;
      int unsigned ticks;
      int unsigned how;
      int unsigned roll;
      int unsigned burst_len;
      bit t;
      if (wild) begin
         k1   = SAMPLE_BITS'($urandom);
         cv   = SAMPLE_BITS'($urandom);
         k2   = SAMPLE_BITS'($urandom);
         span = $urandom_range(5, 40);
      end else if (dly) begin
         k1   = SAMPLE_BITS'($urandom_range(0, 30));
         cv   = SAMPLE_BITS'($urandom_range(0, 15));
         k2   = SAMPLE_BITS'($urandom_range(0, 8));
         span = k1 + cv + 4 * k2 + 1 + $urandom_range(2, 12);
      end else begin
         k1 = SAMPLE_BITS'($urandom_range(0, 16));
         if ($urandom_range(7) == 0) begin
            cv = SAMPLE_BITS'($urandom);
            k2 = SAMPLE_BITS'($urandom);
         end else begin
            cv = SAMPLE_BITS'($urandom_range(0, 60));
            k2 = SAMPLE_BITS'($urandom_range(0, 60));
         end
         burst_len = (int'(cv) + int'(k2)) / 32 + 1;
         if (burst_len > TIMES_LIMIT) begin
            burst_len = TIMES_CLAMP;
         end
         span = (k1 / 2 + BURST_OFFSET) * (burst_len + 2) + $urandom_range(0, 5);
      end

      // Arm with a gate edge, a button edge or both at once.
      how = $urandom_range(0, 2);
      put(1'b0, dly, 1'b1, (how != 1) ? 1'b0 : gate_now, (how != 0) ? 1'b1 : button_now,
          k1, cv, k2);
      put(1'b0, dly, 1'b1, (how != 1) ? 1'b1 : gate_now, (how != 0) ? 1'b0 : button_now,
          k1, cv, k2);

      ticks = 0;
      while (ticks < span) begin
         t    = ($urandom_range(99) < 90);
         roll = $urandom_range(99);
         if (roll < 1) begin
            put(t, !dly, 1'b1, gate_now, button_now, k1, cv, k2);
         end else if (roll < 4) begin
            put(t, dly, 1'b1, !gate_now, button_now, k1, cv, k2);
         end else if (roll < 7) begin
            put(t, dly, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), k1, cv, k2);
         end else if (roll < 10) begin
            k1 = k1 ^ (SAMPLE_BITS'(1) << $urandom_range(0, 2));
            put(t, dly, 1'b1, gate_now, button_now, k1, cv, k2);
         end else begin
            put(t, dly, 1'b1, gate_now, button_now, k1, cv, k2);
         end
         ticks += 32'(t);
      end
   endtask

   // The receiver stalls at random and, twice, holds off long enough for the
   // block to fill up and stop taking requests.
   initial begin
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle == 400 || rx_cycle == 1500) begin
            rx_hold = 150;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("gate_delay_burst_generator_tb: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Delay mode: zero delay and the shortest width, then clamped delay by the button.
      put(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 10'd0, 10'd0);
      put(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 10'd0, 10'd0);
      put(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 10'd0, 10'd0);
      put(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023);
      put(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023);
      // Both edges together act as one trigger.
      put(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023);
      put(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023);
      // Disabled: edges are not seen and the history stays frozen.
      put(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023);
      put(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 10'd1023, 10'd1023, 10'd1023);
      put(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 10'd0, 10'd0);
      // Burst mode: clamped count, a count of exactly 33, and one above it.
      put(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 10'd0, 10'd1023, 10'd1023);
      put(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 10'd1023, 10'd1023);
      put(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 10'd1023, 10'd512, 10'd512);
      put(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 10'd1023, 10'd544, 10'd512);
      put(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 10'd1022, 10'd0, 10'd0);
      put(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 10'd1, 10'd31, 10'd0);
      put(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd1023, 10'd1023, 10'd1023);

      while (sent_count < RANDOM_ITEMS) begin
         calm <= (sent_count > 700 && sent_count < 1000);
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 8)) begin
               put(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), SAMPLE_BITS'($urandom),
                   SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
            end
         end else begin
            run_scene(1'($urandom_range(1)), $urandom_range(9) == 0);
         end
      end
      calm <= 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("gate_delay_burst_generator_tb: clean");
      end else begin
         $display("gate_delay_burst_generator_tb: errors");
      end
      $finish;
   end

endmodule
